// ----- rtl/cgp_pkg.sv -----
// ----------------------------------------------------------------------------
// cgp_pkg: shared types and constants of the gateway command parser
// Command codes, reply kinds and the command record that travels from the
// parser front end to the reply/frame back end.
// ----------------------------------------------------------------------------
`default_nettype none

package cgp_pkg;

  localparam logic [7:0]  HDR_BYTE       = 8'hF1;
  localparam logic [7:0]  BIN_ENABLE     = 8'hE7;
  localparam logic [7:0]  CMD_FRAME      = 8'h00;
  localparam logic [7:0]  CMD_TIME_SYNC  = 8'h01;
  localparam logic [7:0]  CMD_BUS_PARAM  = 8'h06;
  localparam logic [7:0]  CMD_DEV_INFO   = 8'h07;
  localparam logic [7:0]  CMD_KEEP_ALIVE = 8'h09;
  localparam logic [7:0]  CMD_BUS_COUNT  = 8'h0C;
  localparam logic [7:0]  KEEP_ALIVE_B2  = 8'hDE;
  localparam logic [7:0]  KEEP_ALIVE_B3  = 8'hAD;

  localparam int          SPEED_W        = 23;
  localparam logic [22:0] SPEED_RESET    = 23'd500000;
  localparam int          CMDQ_DEPTH     = 2;

  typedef enum logic [2:0] {
    OP_FRAME      = 3'd0,
    OP_KEEP_ALIVE = 3'd1,
    OP_TIME_SYNC  = 3'd2,
    OP_DEV_INFO   = 3'd3,
    OP_BUS_PARAM  = 3'd4,
    OP_BUS_COUNT  = 3'd5
  } op_t;

  // one queued command; time-sync carries the timestamp in data[31:0]
  typedef struct packed {
    op_t         op;
    logic        bin;
    logic [28:0] id;
    logic        ext;
    logic [3:0]  dlc;
    logic [63:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/cgp_front.sv -----
// ----------------------------------------------------------------------------
// cgp_front: host byte parser
// Tracks the command framing byte by byte and pushes one command record per
// reply or CAN frame into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cgp_front
  import cgp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [31:0] in_now_us,
  input  wire q_stat_t     q_stat,
  output logic             q_push,
  output cmd_t             q_wdata
);

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_CMD   = 7'b0000010,
    PH_ID    = 7'b0000100,
    PH_FLAGS = 7'b0001000,
    PH_DLC   = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_TRAIL = 7'b1000000
  } phase_t;

  phase_t      ph_r, ph_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [31:0] id_r, id_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [63:0] data_r, data_nxt;
  logic        bin_r, bin_nxt;
  logic        accept;

  assign in_ready = ~q_stat.full;
  assign accept   = in_valid & in_ready;

  always_comb begin
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    id_nxt   = id_r;
    len_nxt  = len_r;
    data_nxt = data_r;
    bin_nxt  = bin_r;
    q_push   = 1'b0;
    q_wdata  = '0;
    q_wdata.bin = bin_r;
    if (accept) begin
      case (ph_r)
        PH_IDLE: begin
          if (in_rx_byte == BIN_ENABLE) begin
            bin_nxt = 1'b1;
          end else if (in_rx_byte == HDR_BYTE) begin
            ph_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          ph_nxt = PH_IDLE;
          case (in_rx_byte)
            CMD_FRAME: begin
              ph_nxt   = PH_ID;
              cnt_nxt  = '0;
              id_nxt   = '0;
              len_nxt  = '0;
              data_nxt = '0;
            end
            BIN_ENABLE: bin_nxt = 1'b1;
            CMD_KEEP_ALIVE: begin
              q_push     = 1'b1;
              q_wdata.op = OP_KEEP_ALIVE;
            end
            CMD_TIME_SYNC: begin
              q_push       = 1'b1;
              q_wdata.op   = OP_TIME_SYNC;
              q_wdata.data = {32'd0, in_now_us};
            end
            CMD_DEV_INFO: begin
              q_push     = 1'b1;
              q_wdata.op = OP_DEV_INFO;
            end
            CMD_BUS_PARAM: begin
              q_push     = 1'b1;
              q_wdata.op = OP_BUS_PARAM;
            end
            CMD_BUS_COUNT: begin
              q_push     = 1'b1;
              q_wdata.op = OP_BUS_COUNT;
            end
            default: ;
          endcase
        end
        PH_ID: begin
          // little-endian ID, four bytes
          id_nxt[{cnt_r[1:0], 3'b000} +: 8] = in_rx_byte;
          cnt_nxt = cnt_r + 8'd1;
          if (cnt_r[1:0] == 2'd3) begin
            cnt_nxt = '0;
            ph_nxt  = PH_FLAGS;
          end
        end
        PH_FLAGS: ph_nxt = PH_DLC;
        PH_DLC: begin
          len_nxt = in_rx_byte;
          cnt_nxt = '0;
          ph_nxt  = (in_rx_byte == 8'd0) ? PH_TRAIL : PH_DATA;
        end
        PH_DATA: begin
          // bytes past the eighth are swallowed
          if (cnt_r < 8'd8) begin
            data_nxt[{cnt_r[2:0], 3'b000} +: 8] = in_rx_byte;
          end
          cnt_nxt = cnt_r + 8'd1;
          if (({1'b0, cnt_r} + 9'd1) >= {1'b0, len_r}) begin
            ph_nxt = PH_TRAIL;
          end
        end
        PH_TRAIL: begin
          q_push       = 1'b1;
          q_wdata.op   = OP_FRAME;
          q_wdata.ext  = id_r[31];
          q_wdata.id   = id_r[31] ? id_r[28:0] : {18'd0, id_r[10:0]};
          q_wdata.dlc  = (len_r > 8'd8) ? 4'd8 : len_r[3:0];
          q_wdata.data = data_r;
          ph_nxt       = PH_IDLE;
          cnt_nxt      = '0;
        end
        default: ph_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      cnt_r  <= '0;
      id_r   <= '0;
      len_r  <= '0;
      data_r <= '0;
      bin_r  <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
      id_r   <= id_nxt;
      len_r  <= len_nxt;
      data_r <= data_nxt;
      bin_r  <= bin_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cgp_cmdq.sv -----
// ----------------------------------------------------------------------------
// cgp_cmdq: command queue
// Small FIFO of command records between the parser and the reply sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cgp_cmdq
  import cgp_pkg::*;
#(
  parameter int DEPTH = CMDQ_DEPTH
)(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_push,
  input  wire cmd_t q_wdata,
  input  wire logic q_pop,
  output cmd_t      q_head,
  output q_stat_t   q_stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_head       = mem[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_FULL);
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({q_push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem[wr_ptr_r] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cgp_back.sv -----
// ----------------------------------------------------------------------------
// cgp_back: reply and frame sequencer
// Expands the command at the head of the queue into result items, one per
// cycle while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cgp_back
  import cgp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [SPEED_W-1:0] bus_speed,
  input  wire cmd_t               q_head,
  input  wire q_stat_t            q_stat,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_result_kind,
  output logic [7:0]              out_resp_byte,
  output logic [28:0]             out_can_id,
  output logic                    out_can_ext,
  output logic [3:0]              out_can_dlc,
  output logic [63:0]             out_can_data,
  output logic                    out_binary_mode,
  output logic                    out_last
);

  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  last_idx;
  logic [7:0]  cmd_code;
  logic [7:0]  rbyte;
  logic        is_last;
  logic        load;
  logic        fire;

  logic        valid_r;
  logic        kind_r;
  logic [7:0]  resp_r;
  logic [28:0] id_r;
  logic        ext_r;
  logic [3:0]  dlc_r;
  logic [63:0] data_r;
  logic        bin_r;
  logic        last_r;

  always_comb begin
    case (q_head.op)
      OP_KEEP_ALIVE: begin last_idx = 4'd3;  cmd_code = CMD_KEEP_ALIVE; end
      OP_TIME_SYNC:  begin last_idx = 4'd5;  cmd_code = CMD_TIME_SYNC;  end
      OP_DEV_INFO:   begin last_idx = 4'd7;  cmd_code = CMD_DEV_INFO;   end
      OP_BUS_PARAM:  begin last_idx = 4'd11; cmd_code = CMD_BUS_PARAM;  end
      OP_BUS_COUNT:  begin last_idx = 4'd2;  cmd_code = CMD_BUS_COUNT;  end
      default:       begin last_idx = 4'd0;  cmd_code = CMD_FRAME;      end
    endcase
  end

  // reply byte at position idx_r; header and command code lead every reply
  always_comb begin
    rbyte = 8'h00;
    case (idx_r)
      4'd0: rbyte = HDR_BYTE;
      4'd1: rbyte = cmd_code;
      default: begin
        case (q_head.op)
          OP_KEEP_ALIVE: rbyte = (idx_r == 4'd2) ? KEEP_ALIVE_B2 : KEEP_ALIVE_B3;
          OP_TIME_SYNC:  rbyte = q_head.data[{idx_r[1:0] - 2'd2, 3'b000} +: 8];
          OP_DEV_INFO: begin
            if (idx_r == 4'd2 || idx_r == 4'd4) begin
              rbyte = 8'h01;
            end else if (idx_r == 4'd5) begin
              rbyte = {7'd0, q_head.bin};
            end
          end
          OP_BUS_PARAM: begin
            case (idx_r)
              4'd2:    rbyte = 8'h01;
              4'd3:    rbyte = bus_speed[7:0];
              4'd4:    rbyte = bus_speed[15:8];
              4'd5:    rbyte = {1'b0, bus_speed[22:16]};
              default: rbyte = 8'h00;
            endcase
          end
          OP_BUS_COUNT:  rbyte = 8'h01;
          default:       rbyte = 8'h00;
        endcase
      end
    endcase
  end

  assign is_last = (q_head.op == OP_FRAME) || (idx_r == last_idx);
  assign load    = ~valid_r | out_ready;
  assign fire    = load & ~q_stat.empty;
  assign q_pop   = fire & is_last;
  assign idx_nxt = fire ? (is_last ? 4'd0 : idx_r + 4'd1) : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (fire) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      bin_r  <= q_head.bin;
      last_r <= is_last;
      if (q_head.op == OP_FRAME) begin
        kind_r <= 1'b1;
        resp_r <= 8'h00;
        id_r   <= q_head.id;
        ext_r  <= q_head.ext;
        dlc_r  <= q_head.dlc;
        data_r <= q_head.data;
      end else begin
        kind_r <= 1'b0;
        resp_r <= rbyte;
        id_r   <= '0;
        ext_r  <= 1'b0;
        dlc_r  <= '0;
        data_r <= '0;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_result_kind = kind_r;
  assign out_resp_byte   = resp_r;
  assign out_can_id      = id_r;
  assign out_can_ext     = ext_r;
  assign out_can_dlc     = dlc_r;
  assign out_can_data    = data_r;
  assign out_binary_mode = bin_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

// ----- rtl/can_gateway_command_parser.sv -----
// ----------------------------------------------------------------------------
// can_gateway_command_parser: host command parser of a CAN-over-link gateway
// Host bytes come in on the in_ channel (valid/ready, one byte per item,
// with the current microsecond time). Results leave on the out_ channel:
// either one reply byte to the host (out_result_kind 0) or one CAN frame to
// transmit (out_result_kind 1); out_last marks the final result of a command.
// The cfg_ port writes the bus speed reported by the bus-parameter reply;
// write it only while the block is idle.
// The first result of a command passes through the queue write and then the
// output register. The parser takes one byte per cycle while in_ready is
// high; the output side sends one result per cycle while out_ready is high.
// A two-entry command queue sits between parser and sequencer; in_ready
// drops only when that queue is full, i.e. when reply bytes back up.
// A stalled receiver holds the current result in the output register.
// Reset (synchronous, rst_n low) clears the parser to idle, binary mode
// off, the queue and output empty, and the bus speed to 500000.
// ----------------------------------------------------------------------------
`default_nettype none

module can_gateway_command_parser
  import cgp_pkg::*;
#(
  parameter int QDEPTH = CMDQ_DEPTH
)(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic [31:0]        in_now_us,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_result_kind,
  output logic [7:0]              out_resp_byte,
  output logic [28:0]             out_can_id,
  output logic                    out_can_ext,
  output logic [3:0]              out_can_dlc,
  output logic [63:0]             out_can_data,
  output logic                    out_binary_mode,
  output logic                    out_last,
  input  wire logic               cfg_we,
  input  wire logic [SPEED_W-1:0] cfg_wdata
);

  logic [SPEED_W-1:0] speed_r;
  logic               q_push;
  logic               q_pop;
  cmd_t               q_wdata;
  cmd_t               q_head;
  q_stat_t            q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RESET;
    end else if (cfg_we) begin
      speed_r <= cfg_wdata;
    end
  end

  cgp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .in_now_us  (in_now_us),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  cgp_cmdq #(.DEPTH(QDEPTH)) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_stat  (q_stat)
  );

  cgp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .bus_speed       (speed_r),
    .q_head          (q_head),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_resp_byte   (out_resp_byte),
    .out_can_id      (out_can_id),
    .out_can_ext     (out_can_ext),
    .out_can_dlc     (out_can_dlc),
    .out_can_data    (out_can_data),
    .out_binary_mode (out_binary_mode),
    .out_last        (out_last)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("command queue underflow");

  a_dlc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind |-> out_can_dlc <= 4'd8 && out_last)
    else $error("frame result with bad dlc or not last");

  a_std_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind && !out_can_ext |-> out_can_id[28:11] == '0)
    else $error("standard id wider than 11 bits");

  a_reply_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |-> out_can_dlc == '0 && out_can_data == '0)
    else $error("reply byte carries frame fields");
`endif

endmodule

`default_nettype wire
